FILE: sv/pssv_pkg.sv
// Types, constants and helper functions shared by the setpoint slew supervisor.
package pssv_pkg;

  localparam int CountWidth    = 32;
  localparam int DiffWidth     = CountWidth + 1;
  localparam int TravelWidth   = 10;
  localparam int StepWidth     = 5;
  localparam int FollowWidth   = 10;
  localparam int TolWidth      = 8;
  localparam int SettleWidth   = 8;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 10;
  localparam int ReqWidth      = 2;
  localparam int FaultWidth    = 2;

  localparam logic [TravelWidth-1:0] MaxTravelReset   = TravelWidth'(1000);
  localparam logic [StepWidth-1:0]   MaxStepReset     = StepWidth'(1);
  localparam logic [FollowWidth-1:0] MaxFollowReset   = FollowWidth'(1000);
  localparam logic [TolWidth-1:0]    SettleTolReset   = TolWidth'(8);
  localparam logic [SettleWidth-1:0] SettleCyclesReset = SettleWidth'(10);

  typedef enum logic [ReqWidth-1:0] {
    ReqCycle   = 2'd0,
    ReqEnable  = 2'd1,
    ReqDisable = 2'd2
  } req_e;

  typedef enum logic [FaultWidth-1:0] {
    FaultNone      = 2'd0,
    FaultDrive     = 2'd1,
    FaultTravel    = 2'd2,
    FaultFollowing = 2'd3
  } fault_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgMaxTravel    = 3'd0,
    CfgMaxStep      = 3'd1,
    CfgMaxFollowing = 3'd2,
    CfgSettleTol    = 3'd3,
    CfgSettleCycles = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [TravelWidth-1:0] travel_limit;
    logic [StepWidth-1:0]   step_limit;
    logic [FollowWidth-1:0] max_following_error;
    logic [TolWidth-1:0]    settle_tolerance;
    logic [SettleWidth-1:0] settle_cycles;
  } cfg_t;

  typedef struct packed {
    logic [ReqWidth-1:0]          req_type;
    logic signed [CountWidth-1:0] target_count;
    logic signed [CountWidth-1:0] actual_count;
    logic                         drive_ok;
  } item_t;

  typedef struct packed {
    logic                         enabled;
    logic signed [CountWidth-1:0] origin_count;
    logic signed [CountWidth-1:0] applied_count;
    logic                         moving;
    logic [SettleWidth-1:0]       settle_counter;
  } state_t;

  typedef struct packed {
    logic                         command_valid;
    logic signed [CountWidth-1:0] command_count;
    logic                         drive_enable;
    logic                         arm_trigger;
    logic                         commit_trigger;
    logic                         motion_busy;
    logic [FaultWidth-1:0]        fault_code;
  } result_t;

  // Exact distance between two signed positions.
  function automatic logic [DiffWidth-1:0] abs_diff(
    input logic signed [CountWidth-1:0] a,
    input logic signed [CountWidth-1:0] b
  );
    logic signed [DiffWidth-1:0] d;
    d = {a[CountWidth-1], a} - {b[CountWidth-1], b};
    return d[DiffWidth-1] ? DiffWidth'(-d) : DiffWidth'(d);
  endfunction

endpackage

FILE: sv/pssv_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface pssv_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [pssv_pkg::ReqWidth-1:0]          req_type;
  logic signed [pssv_pkg::CountWidth-1:0] target_count;
  logic signed [pssv_pkg::CountWidth-1:0] actual_count;
  logic                                   drive_ok;

  modport source (output valid, req_type, target_count, actual_count, drive_ok,
                  input ready);
  modport sink (input valid, req_type, target_count, actual_count, drive_ok,
                output ready);
endinterface

interface pssv_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command_valid;
  logic signed [pssv_pkg::CountWidth-1:0] command_count;
  logic                                   drive_enable;
  logic                                   arm_trigger;
  logic                                   commit_trigger;
  logic                                   motion_busy;
  logic [pssv_pkg::FaultWidth-1:0]        fault_code;

  modport source (output valid, command_valid, command_count, drive_enable, arm_trigger,
                  commit_trigger, motion_busy, fault_code, input ready);
  modport sink (input valid, command_valid, command_count, drive_enable, arm_trigger,
                commit_trigger, motion_busy, fault_code, output ready);
endinterface

interface pssv_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pssv_pkg::CfgIndexWidth-1:0] index;
  logic [pssv_pkg::CfgDataWidth-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/pssv_step.sv
// Next supervisor state and result for one registered request.
module pssv_step (
  input  pssv_pkg::item_t   item_i,
  input  pssv_pkg::state_t  state_i,
  input  pssv_pkg::cfg_t    cfg_i,
  output pssv_pkg::state_t  state_o,
  output pssv_pkg::result_t result_o
);

  logic [pssv_pkg::DiffWidth-1:0]         travel_dist;
  logic [pssv_pkg::DiffWidth-1:0]         follow_dist;
  logic [pssv_pkg::DiffWidth-1:0]         remain_dist;
  logic [pssv_pkg::DiffWidth-1:0]         settle_dist;
  logic signed [pssv_pkg::CountWidth-1:0] step_ext;
  logic signed [pssv_pkg::CountWidth-1:0] slew_count;
  logic [pssv_pkg::SettleWidth-1:0]       settle_inc;
  pssv_pkg::fault_e                       fault;
  pssv_pkg::state_t                       nxt;
  pssv_pkg::result_t                      res;

  assign travel_dist = pssv_pkg::abs_diff(item_i.target_count, state_i.origin_count);
  assign follow_dist = pssv_pkg::abs_diff(state_i.applied_count, item_i.actual_count);
  assign remain_dist = pssv_pkg::abs_diff(item_i.target_count, state_i.applied_count);
  assign settle_dist = pssv_pkg::abs_diff(item_i.target_count, item_i.actual_count);
  assign step_ext    = signed'(pssv_pkg::CountWidth'(cfg_i.step_limit));
  assign settle_inc  = state_i.settle_counter + pssv_pkg::SettleWidth'(1);

  always_comb begin
    if (remain_dist <= pssv_pkg::DiffWidth'(cfg_i.step_limit)) begin
      slew_count = item_i.target_count;
    end else if (state_i.applied_count < item_i.target_count) begin
      slew_count = state_i.applied_count + step_ext;
    end else begin
      slew_count = state_i.applied_count - step_ext;
    end
  end

  always_comb begin
    if (!item_i.drive_ok) begin
      fault = pssv_pkg::FaultDrive;
    end else if (travel_dist > pssv_pkg::DiffWidth'(cfg_i.travel_limit)) begin
      fault = pssv_pkg::FaultTravel;
    end else if (follow_dist > pssv_pkg::DiffWidth'(cfg_i.max_following_error)) begin
      fault = pssv_pkg::FaultFollowing;
    end else begin
      fault = pssv_pkg::FaultNone;
    end
  end

  always_comb begin
    nxt = state_i;
    res = '0;
    case (item_i.req_type)
      pssv_pkg::ReqEnable: begin
        if (!state_i.enabled) begin
          nxt.origin_count   = item_i.actual_count;
          nxt.applied_count  = item_i.actual_count;
          nxt.enabled        = 1'b1;
          nxt.moving         = 1'b0;
          nxt.settle_counter = '0;
          res.command_valid  = 1'b1;
          res.command_count  = item_i.actual_count;
        end
      end
      pssv_pkg::ReqDisable: begin
        nxt.moving         = 1'b0;
        nxt.settle_counter = '0;
        if (state_i.enabled) begin
          nxt.enabled       = 1'b0;
          res.command_valid = 1'b1;
          res.command_count = item_i.actual_count;
        end
      end
      pssv_pkg::ReqCycle: begin
        if (state_i.enabled) begin
          res.command_valid = 1'b1;
          res.fault_code    = fault;
          if (fault != pssv_pkg::FaultNone) begin
            nxt.enabled        = 1'b0;
            nxt.moving         = 1'b0;
            nxt.settle_counter = '0;
            res.command_count  = item_i.actual_count;
          end else if (item_i.target_count != state_i.applied_count) begin
            if (!state_i.moving) begin
              res.arm_trigger = 1'b1;
            end
            if (!state_i.moving || state_i.settle_counter == '0) begin
              res.commit_trigger = 1'b1;
            end
            nxt.moving         = 1'b1;
            nxt.applied_count  = slew_count;
            nxt.settle_counter = pssv_pkg::SettleWidth'(1);
            res.command_count  = slew_count;
          end else begin
            res.command_count = state_i.applied_count;
            if (state_i.moving) begin
              if (settle_dist <= pssv_pkg::DiffWidth'(cfg_i.settle_tolerance)) begin
                if (settle_inc >= cfg_i.settle_cycles) begin
                  nxt.moving         = 1'b0;
                  nxt.settle_counter = '0;
                end else begin
                  nxt.settle_counter = settle_inc;
                end
              end else begin
                nxt.settle_counter = pssv_pkg::SettleWidth'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.drive_enable = nxt.enabled;
    res.motion_busy  = nxt.moving;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

FILE: sv/position_setpoint_slew_supervisor_core.sv
// Top level of the position setpoint slew supervisor.
// A request is held in the input register; its result then waits in the result register.
// Throughput: one request per cycle while the result register can be loaded, else input stalls.
// The input register and the result register each hold one transfer.
// Reset clears the supervisor state and loads the configuration reset values.
module position_setpoint_slew_supervisor_core (
  input  logic clk_i,
  input  logic rst_ni,
  pssv_in_if.sink    in_i,
  pssv_cfg_if.sink   cfg_i,
  pssv_out_if.source out_o
);

  pssv_pkg::cfg_t    cfg_q;
  pssv_pkg::state_t  state_q;
  pssv_pkg::state_t  state_d;
  pssv_pkg::item_t   item_q;
  pssv_pkg::result_t res_d;
  pssv_pkg::result_t res_q;
  logic              item_valid_q;
  logic              res_valid_q;
  logic              in_fire;
  logic              res_load;

  assign res_load   = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || res_load;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.travel_limit        <= pssv_pkg::MaxTravelReset;
      cfg_q.step_limit          <= pssv_pkg::MaxStepReset;
      cfg_q.max_following_error <= pssv_pkg::MaxFollowReset;
      cfg_q.settle_tolerance    <= pssv_pkg::SettleTolReset;
      cfg_q.settle_cycles       <= pssv_pkg::SettleCyclesReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pssv_pkg::CfgMaxTravel:
          cfg_q.travel_limit <= cfg_i.data[pssv_pkg::TravelWidth-1:0];
        pssv_pkg::CfgMaxStep:
          cfg_q.step_limit <= cfg_i.data[pssv_pkg::StepWidth-1:0];
        pssv_pkg::CfgMaxFollowing:
          cfg_q.max_following_error <= cfg_i.data[pssv_pkg::FollowWidth-1:0];
        pssv_pkg::CfgSettleTol:
          cfg_q.settle_tolerance <= cfg_i.data[pssv_pkg::TolWidth-1:0];
        pssv_pkg::CfgSettleCycles:
          cfg_q.settle_cycles <= cfg_i.data[pssv_pkg::SettleWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.req_type     <= in_i.req_type;
      item_q.target_count <= in_i.target_count;
      item_q.actual_count <= in_i.actual_count;
      item_q.drive_ok     <= in_i.drive_ok;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      state_q      <= '0;
    end else begin
      if (in_fire) begin
        item_valid_q <= 1'b1;
      end else if (res_load) begin
        item_valid_q <= 1'b0;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  pssv_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign out_o.valid          = res_valid_q;
  assign out_o.command_valid  = res_q.command_valid;
  assign out_o.command_count  = res_q.command_count;
  assign out_o.drive_enable   = res_q.drive_enable;
  assign out_o.arm_trigger    = res_q.arm_trigger;
  assign out_o.commit_trigger = res_q.commit_trigger;
  assign out_o.motion_busy    = res_q.motion_busy;
  assign out_o.fault_code     = res_q.fault_code;

  // A motion can only be in progress while the drive is enabled.
  a_moving_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.moving |-> state_q.enabled)
    else $error("motion in progress while drive disabled");

  // A fault result disables the drive, stops motion and still sends a setpoint.
  a_fault_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.fault_code != pssv_pkg::FaultNone) |->
      (!res_q.drive_enable && !res_q.motion_busy && res_q.command_valid))
    else $error("fault result with inconsistent flags");

  // Arming a motion always commits it and marks it busy.
  a_arm_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.arm_trigger) |-> (res_q.commit_trigger && res_q.motion_busy))
    else $error("arm trigger without commit or busy");

  // A processed request always leaves a result behind.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_valid_q)
    else $error("processed request lost its result");

endmodule

FILE: verif/pssv_checker.sv
// Checker that predicts every supervisor result from observed transfers and compares it.
module pssv_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pssv_in_if   in_if,
  pssv_cfg_if  cfg_if,
  pssv_out_if  out_if,
  output int   fail_cnt,
  output int   pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                                   engaged;
  logic signed [pssv_pkg::CountWidth-1:0] origin_pos;
  logic signed [pssv_pkg::CountWidth-1:0] setpoint_pos;
  logic                                   in_motion;
  logic [pssv_pkg::SettleWidth-1:0]       settle_cnt;

  logic [pssv_pkg::TravelWidth-1:0] lim_travel;
  logic [pssv_pkg::StepWidth-1:0]   lim_step;
  logic [pssv_pkg::FollowWidth-1:0] lim_follow;
  logic [pssv_pkg::TolWidth-1:0]    lim_tol;
  logic [pssv_pkg::SettleWidth-1:0] lim_settle;

  pssv_pkg::result_t expected_cmd_q[$];

  task automatic flag_mismatch(string msg);
    fail_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic longint distance(logic signed [pssv_pkg::CountWidth-1:0] a,
                                      logic signed [pssv_pkg::CountWidth-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Advances the supervisor state by one request and returns the command it causes.
  function automatic pssv_pkg::result_t supervise_step(pssv_pkg::item_t it);
    pssv_pkg::result_t                      r;
    pssv_pkg::fault_e                       flt;
    logic signed [pssv_pkg::CountWidth-1:0] rq;
    logic signed [pssv_pkg::CountWidth-1:0] act;
    r   = '0;
    flt = pssv_pkg::FaultNone;
    rq  = it.target_count;
    act = it.actual_count;
    case (it.req_type)
      pssv_pkg::ReqEnable: begin
        if (!engaged) begin
          origin_pos      = act;
          setpoint_pos    = act;
          engaged         = 1'b1;
          in_motion       = 1'b0;
          settle_cnt      = '0;
          r.command_valid = 1'b1;
          r.command_count = act;
        end
      end
      pssv_pkg::ReqDisable: begin
        in_motion  = 1'b0;
        settle_cnt = '0;
        if (engaged) begin
          engaged         = 1'b0;
          r.command_valid = 1'b1;
          r.command_count = act;
        end
      end
      pssv_pkg::ReqCycle: begin
        if (engaged) begin
          if (!it.drive_ok) begin
            flt = pssv_pkg::FaultDrive;
          end else if (distance(rq, origin_pos) > longint'(lim_travel)) begin
            flt = pssv_pkg::FaultTravel;
          end else if (distance(setpoint_pos, act) > longint'(lim_follow)) begin
            flt = pssv_pkg::FaultFollowing;
          end
          r.command_valid = 1'b1;
          if (flt != pssv_pkg::FaultNone) begin
            engaged         = 1'b0;
            in_motion       = 1'b0;
            settle_cnt      = '0;
            r.command_count = act;
          end else if (rq != setpoint_pos) begin
            if (!in_motion) begin
              r.arm_trigger = 1'b1;
              in_motion     = 1'b1;
              settle_cnt    = '0;
            end
            if (distance(rq, setpoint_pos) <= longint'(lim_step)) begin
              setpoint_pos = rq;
            end else if (setpoint_pos < rq) begin
              setpoint_pos = setpoint_pos + pssv_pkg::CountWidth'(lim_step);
            end else begin
              setpoint_pos = setpoint_pos - pssv_pkg::CountWidth'(lim_step);
            end
            r.command_count = setpoint_pos;
            if (settle_cnt == '0) begin
              r.commit_trigger = 1'b1;
            end
            settle_cnt = pssv_pkg::SettleWidth'(1);
          end else begin
            r.command_count = setpoint_pos;
            if (in_motion && distance(rq, act) <= longint'(lim_tol)) begin
              settle_cnt = settle_cnt + pssv_pkg::SettleWidth'(1);
              if (settle_cnt >= lim_settle) begin
                in_motion  = 1'b0;
                settle_cnt = '0;
              end
            end else if (in_motion) begin
              settle_cnt = pssv_pkg::SettleWidth'(1);
            end
          end
        end
      end
      default: ;
    endcase
    r.drive_enable = engaged;
    r.motion_busy  = in_motion;
    r.fault_code   = flt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pssv_pkg::result_t want;
    pssv_pkg::item_t   it;
    if (!rst_ni) begin
      engaged      = 1'b0;
      origin_pos   = '0;
      setpoint_pos = '0;
      in_motion    = 1'b0;
      settle_cnt   = '0;
      lim_travel   = pssv_pkg::MaxTravelReset;
      lim_step     = pssv_pkg::MaxStepReset;
      lim_follow   = pssv_pkg::MaxFollowReset;
      lim_tol      = pssv_pkg::SettleTolReset;
      lim_settle   = pssv_pkg::SettleCyclesReset;
      expected_cmd_q.delete();
      pending_cnt = 0;
    end else begin
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (expected_cmd_q.size() == 0) begin
          flag_mismatch("result transfer with no prediction waiting");
        end else begin
          want = expected_cmd_q.pop_front();
          if (out_if.command_valid !== want.command_valid) begin
            flag_mismatch($sformatf("command_valid got %b want %b",
                                    out_if.command_valid, want.command_valid));
          end
          if (out_if.command_count !== want.command_count) begin
            flag_mismatch($sformatf("command_count got %0d want %0d",
                                    out_if.command_count, want.command_count));
          end
          if (out_if.drive_enable !== want.drive_enable) begin
            flag_mismatch($sformatf("drive_enable got %b want %b",
                                    out_if.drive_enable, want.drive_enable));
          end
          if (out_if.arm_trigger !== want.arm_trigger) begin
            flag_mismatch($sformatf("arm_trigger got %b want %b",
                                    out_if.arm_trigger, want.arm_trigger));
          end
          if (out_if.commit_trigger !== want.commit_trigger) begin
            flag_mismatch($sformatf("commit_trigger got %b want %b",
                                    out_if.commit_trigger, want.commit_trigger));
          end
          if (out_if.motion_busy !== want.motion_busy) begin
            flag_mismatch($sformatf("motion_busy got %b want %b",
                                    out_if.motion_busy, want.motion_busy));
          end
          if (out_if.fault_code !== want.fault_code) begin
            flag_mismatch($sformatf("fault_code got %0d want %0d",
                                    out_if.fault_code, want.fault_code));
          end
        end
      end
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        it.req_type     = in_if.req_type;
        it.target_count = in_if.target_count;
        it.actual_count = in_if.actual_count;
        it.drive_ok     = in_if.drive_ok;
        expected_cmd_q.push_back(supervise_step(it));
      end
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) begin
        case (cfg_if.index)
          pssv_pkg::CfgMaxTravel:
            lim_travel = cfg_if.data[pssv_pkg::TravelWidth-1:0];
          pssv_pkg::CfgMaxStep:
            lim_step   = cfg_if.data[pssv_pkg::StepWidth-1:0];
          pssv_pkg::CfgMaxFollowing:
            lim_follow = cfg_if.data[pssv_pkg::FollowWidth-1:0];
          pssv_pkg::CfgSettleTol:
            lim_tol    = cfg_if.data[pssv_pkg::TolWidth-1:0];
          pssv_pkg::CfgSettleCycles:
            lim_settle = cfg_if.data[pssv_pkg::SettleWidth-1:0];
          default: ;
        endcase
      end
      pending_cnt = expected_cmd_q.size();
    end
  end

endmodule

FILE: verif/tb_top.sv
// Top of the setpoint slew supervisor testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [pssv_pkg::CountWidth-1:0] MaxPos =
    {1'b0, {(pssv_pkg::CountWidth-1){1'b1}}};
  localparam logic signed [pssv_pkg::CountWidth-1:0] MinPos =
    {1'b1, {(pssv_pkg::CountWidth-1){1'b0}}};
  localparam logic [pssv_pkg::ReqWidth-1:0]      ReqUnknown  = '1;
  localparam logic [pssv_pkg::CfgIndexWidth-1:0] CfgTopIndex = '1;
  localparam int SegItems = 90;
  localparam int NumSegs  = 6;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   send_pct;
  int   recv_pct;
  int   items_sent;
  int   cur_travel;
  int   cur_step;
  int   cur_tol;
  int   fail_cnt;
  int   pending_cnt;

  pssv_in_if  in_if ();
  pssv_cfg_if cfg_if ();
  pssv_out_if out_if ();

  position_setpoint_slew_supervisor_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  pssv_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_if      (cfg_if),
    .out_if      (out_if),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_pct);
  end

  task automatic send_request(logic [pssv_pkg::ReqWidth-1:0] rt,
                              logic signed [pssv_pkg::CountWidth-1:0] rq,
                              logic signed [pssv_pkg::CountWidth-1:0] act, logic ok);
    @(negedge clk_i);
    while ($urandom_range(99) < send_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.req_type     <= rt;
    in_if.target_count <= rq;
    in_if.actual_count <= act;
    in_if.drive_ok     <= ok;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(logic [pssv_pkg::CfgIndexWidth-1:0] idx,
                           logic [pssv_pkg::CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_settings(int travel, int step, int follow, int tol, int cycles);
    write_reg(pssv_pkg::CfgMaxTravel, pssv_pkg::CfgDataWidth'(travel));
    write_reg(pssv_pkg::CfgMaxStep, pssv_pkg::CfgDataWidth'(step));
    write_reg(pssv_pkg::CfgMaxFollowing, pssv_pkg::CfgDataWidth'(follow));
    write_reg(pssv_pkg::CfgSettleTol, pssv_pkg::CfgDataWidth'(tol));
    write_reg(pssv_pkg::CfgSettleCycles, pssv_pkg::CfgDataWidth'(cycles));
    cur_travel = travel;
    cur_step   = step;
    cur_tol    = tol;
  endtask

  task automatic random_settings();
    int follow;
    follow = ($urandom_range(3) == 0) ? $urandom_range(1, 1023) : $urandom_range(40, 1023);
    apply_settings($urandom_range(1, 1023), $urandom_range(1, 31), follow,
                   $urandom_range(0, 255), $urandom_range(1, 24));
  endtask

  // Lets every outstanding result drain so the block is idle before a register write.
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 3)) begin
      send_request(pssv_pkg::ReqWidth'($urandom_range(0, (1 << pssv_pkg::ReqWidth) - 1)),
                   $urandom, $urandom, 1'($urandom_range(1)));
    end
  endtask

  // A well-formed session: a disable, an enable at some origin, one or more moves with a drive
  // that follows the setpoint, occasional faults, and an optional disable.
  task automatic run_motion();
    logic signed [pssv_pkg::CountWidth-1:0] origin;
    logic signed [pssv_pkg::CountWidth-1:0] tgt;
    logic signed [pssv_pkg::CountWidth-1:0] pos;
    logic signed [pssv_pkg::CountWidth-1:0] rq;
    logic signed [pssv_pkg::CountWidth-1:0] act;
    logic                                   ok;
    int                                     reach;
    int                                     jm;
    int                                     pick;
    longint                                 d;
    origin = $urandom;
    pick   = $urandom_range(7);
    if (pick == 0) begin
      origin = MaxPos - $urandom_range(0, 50);
    end else if (pick == 1) begin
      origin = MinPos + $urandom_range(0, 50);
    end
    send_request(pssv_pkg::ReqDisable, $urandom, $urandom, 1'($urandom_range(1)));
    send_request(pssv_pkg::ReqEnable, $urandom, origin, 1'($urandom_range(1)));
    pos = origin;
    jm  = (cur_tol < 3) ? cur_tol : 3;
    repeat ($urandom_range(1, 3)) begin
      reach = (cur_step * 20 < cur_travel) ? cur_step * 20 : cur_travel;
      if (reach < 1) begin
        reach = 1;
      end
      tgt = origin + (int'($urandom_range(0, 2 * reach)) - reach);
      repeat ($urandom_range(10, 60)) begin
        rq   = tgt;
        act  = pos + (int'($urandom_range(0, 2 * jm)) - jm);
        ok   = 1'b1;
        pick = $urandom_range(99);
        if (pick < 2) begin
          ok = 1'b0;
        end else if (pick < 4) begin
          act = pos + 1100 + $urandom_range(0, 100);
        end else if (pick < 6) begin
          rq = $urandom_range(1) ? origin + cur_travel + 1 + $urandom_range(0, 3)
                                 : origin - cur_travel - 1 - $urandom_range(0, 3);
        end
        send_request(pssv_pkg::ReqCycle, rq, act, ok);
        d = longint'(tgt) - longint'(pos);
        if (d > cur_step) begin
          pos = pos + cur_step;
        end else if (d < -cur_step) begin
          pos = pos - cur_step;
        end else begin
          pos = tgt;
        end
      end
    end
    if ($urandom_range(1)) begin
      send_request(pssv_pkg::ReqDisable, $urandom, pos, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int stop;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.req_type     = pssv_pkg::ReqCycle;
    in_if.target_count = '0;
    in_if.actual_count = '0;
    in_if.drive_ok     = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = pssv_pkg::CfgMaxTravel;
    cfg_if.data        = '0;
    out_if.ready       = 1'b0;
    send_pct           = 25;
    recv_pct           = 75;
    items_sent         = 0;
    cur_travel         = int'(pssv_pkg::MaxTravelReset);
    cur_step           = int'(pssv_pkg::MaxStepReset);
    cur_tol            = int'(pssv_pkg::SettleTolReset);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(pssv_pkg::ReqCycle, MaxPos, MinPos, 1'b0);
    send_request(pssv_pkg::ReqDisable, '0, '0, 1'b1);
    send_request(ReqUnknown, MaxPos, MaxPos, 1'b1);
    send_request(pssv_pkg::ReqEnable, '0, MaxPos - 15, 1'b0);
    send_request(pssv_pkg::ReqEnable, '0, '0, 1'b1);
    send_request(pssv_pkg::ReqCycle, MaxPos, MaxPos - 15, 1'b1);
    send_request(pssv_pkg::ReqCycle, MaxPos, MaxPos - 14, 1'b1);
    send_request(pssv_pkg::ReqCycle, MinPos, MaxPos - 13, 1'b1);
    send_request(pssv_pkg::ReqEnable, '0, MinPos, 1'b1);
    send_request(pssv_pkg::ReqCycle, MinPos, MinPos, 1'b0);
    send_request(pssv_pkg::ReqEnable, '0, '0, 1'b1);
    send_request(pssv_pkg::ReqCycle, '0, 1001, 1'b1);
    send_request(pssv_pkg::ReqEnable, '0, 100, 1'b1);
    send_request(pssv_pkg::ReqCycle, 100, 100, 1'b1);
    send_request(pssv_pkg::ReqCycle, 103, 100, 1'b1);
    repeat (3) send_request(pssv_pkg::ReqCycle, 103, 103, 1'b1);
    send_request(pssv_pkg::ReqDisable, '0, 103, 1'b1);

    drain();
    apply_settings(0, 0, 0, 0, 0);
    send_request(pssv_pkg::ReqEnable, '0, 50, 1'b1);
    send_request(pssv_pkg::ReqCycle, 50, 50, 1'b1);
    send_request(pssv_pkg::ReqCycle, 51, 50, 1'b1);
    send_request(pssv_pkg::ReqEnable, '0, 50, 1'b1);
    send_request(pssv_pkg::ReqCycle, 50, 51, 1'b1);
    drain();
    apply_settings(1000, 0, 1000, 8, 0);
    send_request(pssv_pkg::ReqEnable, '0, '0, 1'b1);
    send_request(pssv_pkg::ReqCycle, 10, '0, 1'b1);
    send_request(pssv_pkg::ReqCycle, '0, '0, 1'b1);

    for (int seg = 0; seg < NumSegs; seg++) begin
      drain();
      send_pct = (seg < 2) ? 25 : (seg < 4) ? 75 : 0;
      recv_pct = (seg < 2) ? 75 : (seg < 4) ? 25 : 0;
      case (seg)
        0:       apply_settings(1000, 20, 1023, 0, 1);
        2:       apply_settings(1023, 31, 1023, 255, 255);
        4:       apply_settings(1, 1, 1, 0, 1);
        default: random_settings();
      endcase
      if (seg == 1) begin
        write_reg(pssv_pkg::CfgIndexWidth'($urandom_range(pssv_pkg::CfgSettleCycles + 1,
                                                           CfgTopIndex)),
                  pssv_pkg::CfgDataWidth'($urandom));
      end
      stop = items_sent + SegItems;
      while (items_sent < stop) begin
        if ($urandom_range(5) == 0) begin
          noise_burst();
        end else begin
          run_motion();
        end
      end
    end

    drain();
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
sv/pssv_pkg.sv
sv/pssv_if.sv
sv/pssv_step.sv
sv/position_setpoint_slew_supervisor_core.sv
verif/pssv_checker.sv
verif/tb_top.sv
